[rtl/b64d_pkg.sv]
package b64d_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Default depth of the group queue between the front and the back part.
    localparam int GROUP_FIFO_DEPTH = 4;

    // One decoded group: up to three bytes, most significant byte first.
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  count;
        logic        last;
    } group_t;

    // Maps a character to its sextet for both the standard and URL-safe alphabets.
    function automatic logic [5:0] to_sextet(input logic [7:0] c);
        logic [7:0] d;
        unique case (c) inside
            [8'h41:8'h5A]:          d = c - 8'h41;
            [8'h61:8'h7A]:          d = c - 8'h47;
            [8'h30:8'h39]:          d = c + 8'h04;
            8'h2B, 8'h2D, 8'h2E:    d = 8'd62;
            8'h2F, 8'h5F, 8'h2C:    d = 8'd63;
            default:                d = 8'd0;
        endcase
        return d[5:0];
    endfunction

endpackage

[rtl/b64d_front.sv]
module b64d_front
    import b64d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] text_char,
    input  logic       is_final,
    input  logic       fifo_full,
    output logic       full,
    output logic       grp_valid,
    output group_t     grp
);

    logic [17:0] acc_reg, acc_next;
    logic [1:0]  pos_reg, pos_next;
    logic        third_pad_reg, third_pad_next;
    logic        accept;
    logic [5:0]  sextet;
    logic        is_pad;

    assign full   = fifo_full;
    assign accept = push && !fifo_full;
    assign sextet = to_sextet(text_char);
    assign is_pad = (text_char == PAD_CHAR);

    always_comb
    begin
        acc_next       = acc_reg;
        pos_next       = pos_reg;
        third_pad_next = third_pad_reg;
        grp_valid      = 1'b0;
        grp.bits       = {acc_reg, sextet};
        grp.count      = 2'd3;
        grp.last       = is_final;
        if (accept)
        begin
            if (!is_final && pos_reg != 2'd3)
            begin
                acc_next = {acc_reg[11:0], sextet};
                pos_next = pos_reg + 2'd1;
                if (pos_reg == 2'd2)
                begin
                    third_pad_next = is_pad;
                end
            end
            else
            begin
                // A full group, or the final character closing a short group.
                grp_valid      = 1'b1;
                acc_next       = '0;
                pos_next       = '0;
                third_pad_next = 1'b0;
                if (is_final)
                begin
                    case (pos_reg)
                        2'd0:
                        begin
                            grp.bits  = {sextet, 18'd0};
                            grp.count = 2'd1;
                        end
                        2'd1:
                        begin
                            grp.bits  = {acc_reg[5:0], sextet, 12'd0};
                            grp.count = 2'd1;
                        end
                        2'd2:
                        begin
                            grp.bits  = {acc_reg[11:0], sextet, 6'd0};
                            grp.count = is_pad ? 2'd1 : 2'd2;
                        end
                        default:
                        begin
                            grp.bits  = {acc_reg, sextet};
                            grp.count = is_pad ? (third_pad_reg ? 2'd1 : 2'd2) : 2'd3;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            pos_reg       <= '0;
            third_pad_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            pos_reg       <= pos_next;
            third_pad_reg <= third_pad_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_final_resets: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_final |=> pos_reg == 2'd0 && !third_pad_reg)
        else $error("group position not cleared after final character");
    a_group_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        grp_valid |-> grp.count != 2'd0)
        else $error("group with no bytes issued");
    a_push_only_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        grp_valid |-> accept)
        else $error("group issued without an accepted beat");
`endif

endmodule

[rtl/b64d_group_fifo.sv]
module b64d_group_fifo
    import b64d_pkg::*;
#(
    parameter int DEPTH = GROUP_FIFO_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  group_t wr_data,
    output logic   full,
    input  logic   rd_en,
    output logic   head_valid,
    output group_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    group_t          mem [DEPTH];
    group_t          head_reg;
    logic            head_valid_reg;
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   cnt_reg;
    logic            head_free, take_mem, bypass, write_mem;

    assign full       = (cnt_reg == DEPTH_C);
    assign head_valid = head_valid_reg;
    assign head       = head_reg;
    assign head_free  = !head_valid_reg || rd_en;
    assign take_mem   = head_free && (cnt_reg != '0);
    assign bypass     = head_free && (cnt_reg == '0) && wr_en;
    assign write_mem  = wr_en && !bypass;

    always_ff @(posedge clk)
    begin
        if (write_mem)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
        if (take_mem)
        begin
            head_reg <= mem[rd_ptr_reg];
        end
        else if (bypass)
        begin
            head_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            if (head_free)
            begin
                head_valid_reg <= take_mem || bypass;
            end
            if (write_mem)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (take_mem)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            end
            cnt_reg <= cnt_reg + CW'(write_mem) - CW'(take_mem);
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH_C)
        else $error("group queue count beyond depth");
    a_head_first: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid_reg |-> cnt_reg == '0)
        else $error("stored groups behind an empty head");
    a_write_seen: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> head_valid_reg)
        else $error("queue empty after a write");
`endif

endmodule

[rtl/b64d_back.sv]
module b64d_back
    import b64d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       grp_valid,
    input  group_t     grp,
    output logic       grp_pop,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic       out_last
);

    group_t     cur_reg;
    logic       valid_reg;
    logic [1:0] idx_reg;
    logic       last_byte, pop_ok, take;

    assign last_byte = (idx_reg == cur_reg.count - 2'd1);
    assign pop_ok    = pop && valid_reg;
    assign take      = !valid_reg || (pop_ok && last_byte);
    assign grp_pop   = take && grp_valid;
    assign empty     = !valid_reg;
    assign out_last  = cur_reg.last && last_byte;

    always_comb
    begin
        case (idx_reg)
            2'd0:    out_byte = cur_reg.bits[23:16];
            2'd1:    out_byte = cur_reg.bits[15:8];
            default: out_byte = cur_reg.bits[7:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (grp_pop)
        begin
            cur_reg <= grp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (take)
        begin
            valid_reg <= grp_valid;
            idx_reg   <= '0;
        end
        else if (pop_ok)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> cur_reg.count != 2'd0)
        else $error("held group has no bytes");
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> idx_reg < cur_reg.count)
        else $error("byte index beyond group length");
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        pop_ok && !last_byte |=> valid_reg && idx_reg == $past(idx_reg) + 2'd1)
        else $error("byte index did not advance");
`endif

endmodule

[rtl/base64_decoder_unit.sv]
// A completed group passes the queue's head register, then the back part's group register.
// Throughput: one character beat per cycle while full is low; the back part sends one byte
// per cycle while pop is held, so four characters give three bytes with room to spare, held
// in the group queue. A full group gives three bytes, a final group one to three.
// Reset: rst_n is asynchronous and active low; it empties the queue and clears the group state.
// No clearing pass is needed, so the block accepts beats right after reset.
module base64_decoder_unit
    import b64d_pkg::*;
#(
    parameter int GROUP_FIFO_DEPTH_P = GROUP_FIFO_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] text_char,
    input  logic       is_final,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       out_last
);

    // The front part maps each character to a sextet and builds groups of up to
    // three bytes. A group goes to the queue when the fourth character arrives,
    // or when the final character of the text closes a short or padded group.
    // The back part takes groups from the queue and hands out one byte per beat.

    group_t front_grp;
    logic   front_grp_valid;
    logic   fifo_full;
    group_t head_grp;
    logic   head_valid;
    logic   head_pop;

    b64d_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .text_char (text_char),
        .is_final  (is_final),
        .fifo_full (fifo_full),
        .full      (full),
        .grp_valid (front_grp_valid),
        .grp       (front_grp)
    );

    // The queue holds its head in a register, so a group written into an empty
    // queue is ready at the next edge.
    b64d_group_fifo #(
        .DEPTH (GROUP_FIFO_DEPTH_P)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (front_grp_valid),
        .wr_data    (front_grp),
        .full       (fifo_full),
        .rd_en      (head_pop),
        .head_valid (head_valid),
        .head       (head_grp)
    );

    // The back part loads the next group in the same cycle its last byte is
    // popped, so bytes of successive groups follow without a gap.
    b64d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_valid (head_valid),
        .grp       (head_grp),
        .grp_pop   (head_pop),
        .pop       (pop),
        .empty     (empty),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

endmodule

[tb/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import b64d_pkg::PAD_CHAR;

    // A directed row with this byte count has no typed answer; the predictor supplies it.
    localparam int USE_MODEL = -1;
    // Cycles without any accepted character or owed byte before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 4000;
    // Cycles waited after the last owed byte, so that any byte nobody owes still shows up.
    localparam int DRAIN_CYCLES = 8;
    // Random characters sent in each idling phase.
    localparam int CHARS_PER_PHASE = 22;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    // One decoded byte as it should leave the block.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } dec_byte_t;

    // One row of the directed table. When nbytes is not USE_MODEL, the bytes that
    // the character yields are typed into word, most significant byte first.
    typedef struct {
        logic [7:0]  ch;
        logic        fin;
        int          nbytes;
        logic [23:0] word;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] text_char;
    logic       is_final;
    logic       empty;
    logic       pop;
    logic [7:0] out_byte;
    logic       out_last;

    base64_decoder_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .text_char (text_char),
        .is_final  (is_final),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    // 20 ns period.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Decoder state as the predictor sees it: the sextets of the open group, how many
    // characters that group holds, and whether its third character was the pad.
    logic [17:0] acc_sextets;
    logic [1:0]  chars_in_group;
    logic        third_was_pad;

    // Bytes that are owed by the block, oldest first.
    dec_byte_t   pending_bytes[$];

    // Typed answer that travels with the beat on the input ports.
    int          row_nbytes;
    logic [23:0] row_word;

    idle_mode_t  idle_mode;
    int          errors;
    int          chars_accepted;
    int          texts_accepted;
    int          bytes_checked;
    int          phase_chars;
    int          stall_cycles;

    string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/-_.,";

    dir_row_t directed_rows [26];

    // Character to sextet. Both alphabets and the extra codes . and , are accepted;
    // the pad and every other character count as zero.
    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
            return 6'(c - "A");
        if (c >= "a" && c <= "z")
            return 6'(c - "a" + 8'd26);
        if (c >= "0" && c <= "9")
            return 6'(c - "0" + 8'd52);
        if (c == "+" || c == "-" || c == ".")
            return 6'd62;
        if (c == "/" || c == "_" || c == ",")
            return 6'd63;
        return 6'd0;
    endfunction

    // Moves the predicted decoder by one character. Returns how many bytes it yields
    // and leaves them in word, the first byte in the top eight bits.
    function automatic int advance_decoder(input logic [7:0] ch, input logic fin,
                                           output logic [23:0] word);
        logic [5:0] s;
        int         cnt;
        s = sextet_of(ch);
        word = '0;
        if (!fin)
        begin
            if (chars_in_group == 2'd3)
            begin
                // The fourth character closes a group in the middle of the text.
                word = {acc_sextets, s};
                acc_sextets = '0;
                chars_in_group = '0;
                third_was_pad = 1'b0;
                return 3;
            end
            if (chars_in_group == 2'd2)
                third_was_pad = (ch == PAD_CHAR);
            acc_sextets = {acc_sextets[11:0], s};
            chars_in_group = chars_in_group + 2'd1;
            return 0;
        end
        // The final character flushes whatever the group holds.
        case (chars_in_group)
            2'd0:
            begin
                // A lone character pairs with a zero sextet.
                word = {s, 18'd0};
                cnt = 1;
            end
            2'd1:
            begin
                word = {acc_sextets[5:0], s, 12'd0};
                cnt = 1;
            end
            2'd2:
            begin
                word = {acc_sextets[11:0], s, 6'd0};
                cnt = (ch == PAD_CHAR) ? 1 : 2;
            end
            default:
            begin
                word = {acc_sextets, s};
                if (ch == PAD_CHAR)
                    cnt = third_was_pad ? 1 : 2;
                else
                    cnt = 3;
            end
        endcase
        acc_sextets = '0;
        chars_in_group = '0;
        third_was_pad = 1'b0;
        return cnt;
    endfunction

    function automatic bit sender_idles();
        int r;
        r = $urandom_range(0, 99);
        return (idle_mode == IDLE_SENDER && r < 82) || (idle_mode == IDLE_BOTH && r < 26);
    endfunction

    function automatic bit receiver_stalls();
        int r;
        r = $urandom_range(0, 99);
        return (idle_mode == IDLE_RECEIVER && r < 82) || (idle_mode == IDLE_BOTH && r < 26);
    endfunction

    // Offers one character and returns at the edge where the block takes it.
    // The typed answer is driven alongside the data so that it changes with the beat.
    task automatic send_char(input logic [7:0] ch, input logic fin,
                             input int nbytes, input logic [23:0] word);
        while (sender_idles())
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        text_char  <= ch;
        is_final   <= fin;
        row_nbytes <= nbytes;
        row_word   <= word;
        @(posedge clk);
        while (full)
            @(posedge clk);
        phase_chars++;
    endtask

    // One random text. Most texts are made of alphabet characters, with correct
    // padding where the length is a multiple of four; the rest is arbitrary codes
    // with the pad thrown in anywhere.
    task automatic send_text();
        bit         clean;
        int         len;
        int         npad;
        logic [7:0] ch;
        clean = $urandom_range(0, 99) < 80;
        len = $urandom_range(1, 12);
        npad = 0;
        if (clean && len % 4 == 0)
            npad = $urandom_range(0, 2);
        for (int i = 0; i < len; i++)
        begin
            if (i >= len - npad)
                ch = PAD_CHAR;
            else if (clean)
                ch = alphabet[$urandom_range(0, alphabet.len() - 1)];
            else if ($urandom_range(0, 3) == 0)
                ch = PAD_CHAR;
            else
                ch = 8'($urandom_range(0, 255));
            send_char(ch, i == len - 1, USE_MODEL, '0);
        end
    endtask

    // The receiver decides afresh on every edge whether it takes a byte.
    always @(posedge clk)
        pop <= !receiver_stalls();

    // Watches both ports at every edge. An accepted character is run through the
    // predictor and its bytes are queued; an accepted byte is checked against the
    // oldest one queued. The watchdog ends the run if nothing moves for too long;
    // a byte that nobody owes does not count as movement.
    always @(posedge clk)
    begin
        int          n;
        logic [23:0] word;
        dec_byte_t   want;
        bit          moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (push && !full)
            begin
                moved = 1'b1;
                n = advance_decoder(text_char, is_final, word);
                if (row_nbytes != USE_MODEL)
                begin
                    n = row_nbytes;
                    word = row_word;
                end
                for (int k = 0; k < n; k++)
                    pending_bytes.insert(pending_bytes.size(),
                                         {word[23 - 8 * k -: 8], is_final && k == n - 1});
                chars_accepted++;
                if (is_final)
                    texts_accepted++;
            end
            if (pop && !empty)
            begin
                bytes_checked++;
                if (pending_bytes.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: unexpected byte: expected none, actual %h last %b",
                             $time, out_byte, out_last);
                end
                else
                begin
                    moved = 1'b1;
                    want = pending_bytes.pop_front();
                    if (out_byte !== want.data || out_last !== want.last)
                    begin
                        errors++;
                        $display("%0t ns: mismatch: expected %h last %b, actual %h last %b",
                                 $time, want.data, want.last, out_byte, out_last);
                    end
                end
            end
            if (moved)
                stall_cycles = 0;
            else
            begin
                stall_cycles++;
                if (stall_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("%0t ns: no beat for %0d cycles, %0d bytes still owed",
                             $time, stall_cycles, pending_bytes.size());
                    $display("RESULT: ERROR");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        text_char = '0;
        is_final = 1'b0;
        row_nbytes = USE_MODEL;
        row_word = '0;
        idle_mode = IDLE_NONE;
        errors = 0;
        chars_accepted = 0;
        texts_accepted = 0;
        bytes_checked = 0;
        phase_chars = 0;
        stall_cycles = 0;
        acc_sextets = '0;
        chars_in_group = '0;
        third_was_pad = 1'b0;

        // Directed texts. Where the decoded bytes are plain ASCII they are typed in;
        // the alphabet variants and the odd codes go through the predictor.
        directed_rows = '{
            // A lone final character pairs with a zero sextet.
            '{"A",      1'b1, 1,         24'h000000},
            // Full final group with no padding.
            '{"Q",      1'b0, 0,         24'h000000},
            '{"U",      1'b0, 0,         24'h000000},
            '{"J",      1'b0, 0,         24'h000000},
            '{"D",      1'b1, 3,         24'h414243},
            // Two pad characters: one byte.
            '{"Q",      1'b0, 0,         24'h000000},
            '{"Q",      1'b0, 0,         24'h000000},
            '{PAD_CHAR, 1'b0, 0,         24'h000000},
            '{PAD_CHAR, 1'b1, 1,         24'h410000},
            // One pad character: two bytes.
            '{"Q",      1'b0, 0,         24'h000000},
            '{"U",      1'b0, 0,         24'h000000},
            '{"I",      1'b0, 0,         24'h000000},
            '{PAD_CHAR, 1'b1, 2,         24'h414200},
            // URL-safe and extra characters in a group that is not the last.
            '{"-",      1'b0, USE_MODEL, 24'h000000},
            '{"_",      1'b0, USE_MODEL, 24'h000000},
            '{".",      1'b0, USE_MODEL, 24'h000000},
            '{",",      1'b0, USE_MODEL, 24'h000000},
            // A pad inside the text, the extreme codes, then the letter z.
            '{PAD_CHAR, 1'b0, USE_MODEL, 24'h000000},
            '{8'hFF,    1'b0, USE_MODEL, 24'h000000},
            '{8'h00,    1'b0, USE_MODEL, 24'h000000},
            '{"z",      1'b0, USE_MODEL, 24'h000000},
            // Short final group of two characters.
            '{"/",      1'b0, USE_MODEL, 24'h000000},
            '{"9",      1'b1, USE_MODEL, 24'h000000},
            // Short final group of three whose last is the pad.
            '{"Q",      1'b0, 0,         24'h000000},
            '{"Q",      1'b0, 0,         24'h000000},
            '{PAD_CHAR, 1'b1, 1,         24'h410000}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_char(directed_rows[i].ch, directed_rows[i].fin,
                      directed_rows[i].nbytes, directed_rows[i].word);

        // Random texts, one batch for each way of idling. Texts are never cut at a
        // phase change, so each phase runs slightly over its share.
        for (int m = IDLE_NONE; m <= IDLE_BOTH; m++)
        begin
            idle_mode = idle_mode_t'(m);
            phase_chars = 0;
            while (phase_chars < CHARS_PER_PHASE)
                send_text();
        end
        push <= 1'b0;

        // The watchdog guards this wait.
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_bytes.size() != 0)
        begin
            errors++;
            $display("%0t ns: %0d bytes never arrived", $time, pending_bytes.size());
        end

        $display("Decoded %0d characters in %0d texts, %0d directed, the rest random,",
                 chars_accepted, texts_accepted, $size(directed_rows));
        $display("under four idling patterns; %0d bytes checked, %0d failures.",
                 bytes_checked, errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/b64d_pkg.sv
rtl/b64d_front.sv
rtl/b64d_group_fifo.sv
rtl/b64d_back.sv
rtl/base64_decoder_unit.sv
tb/testbench.sv
